// ===== rtl/lrme_pkg.sv =====
// Shared constants and types for the letter RSA modular exponentiation block.
package lrme_pkg;

   localparam int MOD_BITS_DEFAULT = 16;
   localparam int CHAR_BITS        = 8;
   localparam int MAP_BITS         = 5;

   localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_Z     = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [MAP_BITS-1:0]  MAP_FIRST  = 5'd2;
   localparam logic [MAP_BITS-1:0]  MAP_SPACE  = 5'd28;

   localparam int EXPONENT_RESET = 3;
   localparam int MODULUS_RESET  = 3233;

   typedef enum logic [0:0] {
      CSR_EXPONENT = 1'b0,
      CSR_MODULUS  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;
   } stage_ctrl_type;

endpackage

// ===== rtl/letter_rsa_modexp_encrypt.sv =====
// Top level of the letter RSA modular exponentiation block.
// A new item may be started in every cycle and busy is always low. Each result appears
// on the rsp_ ports, marked by rsp_valid for one cycle, after it has passed through
// these registered stages in order: one stage maps and reduces the character,
// one pipeline stage performs each of the MOD_BITS shift-and-add steps of the
// MOD_BITS exponent bits, and a final stage registers the result. Results leave in
// start order and cannot be held off. Register writes take effect at once and are to
// be made only while no item is in flight.
module letter_rsa_modexp_encrypt #(
   parameter int MOD_BITS = lrme_pkg::MOD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lrme_pkg::CHAR_BITS-1:0] req_char_code,
   output logic                           rsp_valid,
   output logic [MOD_BITS-1:0]            rsp_cipher_value,
   input  logic                           csr_we,
   input  lrme_pkg::csr_index_type        csr_index,
   input  logic [MOD_BITS-1:0]            csr_wdata
);
   import lrme_pkg::*;

   localparam int STEPS = MOD_BITS * MOD_BITS;

   logic [MOD_BITS-1:0] exponent_ff, modulus_ff;
   stage_ctrl_type      front_ctrl;
   stage_ctrl_type      ctrl   [0:STEPS];
   logic [MOD_BITS-1:0] base   [0:STEPS];
   logic [MOD_BITS-1:0] result [0:STEPS];
   logic [MOD_BITS-1:0] acc_sq [0:STEPS];
   logic [MOD_BITS-1:0] acc_mul[0:STEPS];
   logic                rsp_valid_ff;
   logic [MOD_BITS-1:0] rsp_value_ff, rsp_value_in;

   assign busy             = 1'b0;
   assign front_ctrl.valid = start;

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= MOD_BITS'(EXPONENT_RESET);
         modulus_ff  <= MOD_BITS'(MODULUS_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPONENT: exponent_ff <= csr_wdata;
            CSR_MODULUS:  modulus_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   lrme_front #(.MOD_BITS(MOD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .ctrl_in   (front_ctrl),
      .char_code (req_char_code),
      .modulus   (modulus_ff),
      .ctrl_out  (ctrl[0]),
      .base_out  (base[0])
   );

   assign result[0]  = MOD_BITS'(1);
   assign acc_sq[0]  = '0;
   assign acc_mul[0] = '0;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      lrme_step #(
         .MOD_BITS (MOD_BITS),
         .BIT_IDX  (MOD_BITS - 1 - (k % MOD_BITS)),
         .FIRST    ((k % MOD_BITS) == 0),
         .LAST     ((k % MOD_BITS) == MOD_BITS - 1)
      ) u_step (
         .clock        (clock),
         .reset        (reset),
         .ctrl_in      (ctrl[k]),
         .base_in_d    (base[k]),
         .result_in_d  (result[k]),
         .acc_sq_in_d  (acc_sq[k]),
         .acc_mul_in_d (acc_mul[k]),
         .modulus      (modulus_ff),
         .exp_bit      (exponent_ff[k / MOD_BITS]),
         .ctrl_out     (ctrl[k+1]),
         .base_out     (base[k+1]),
         .result_out   (result[k+1]),
         .acc_sq_out   (acc_sq[k+1]),
         .acc_mul_out  (acc_mul[k+1])
      );
   end

   always_comb begin
      if (modulus_ff == '0) begin
         rsp_value_in = '0;
      end else if (exponent_ff == '0) begin
         rsp_value_in = MOD_BITS'(1);
      end else begin
         rsp_value_in = result[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl[STEPS].valid;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cipher_value = rsp_value_ff;

endmodule

// ===== rtl/lrme_front.sv =====
// Front stage: maps the character code and reduces it modulo the modulus.
module lrme_front #(
   parameter int MOD_BITS = lrme_pkg::MOD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lrme_pkg::stage_ctrl_type       ctrl_in,
   input  logic [lrme_pkg::CHAR_BITS-1:0] char_code,
   input  logic [MOD_BITS-1:0]            modulus,
   output lrme_pkg::stage_ctrl_type       ctrl_out,
   output logic [MOD_BITS-1:0]            base_out
);
   import lrme_pkg::*;

   logic [MAP_BITS-1:0]  mapped;
   logic [MAP_BITS:0]    rem;
   logic [MOD_BITS-1:0]  base_in;
   logic [MOD_BITS-1:0]  base_ff;
   stage_ctrl_type       ctrl_ff;

   always_comb begin
      if (char_code >= CHAR_A && char_code <= CHAR_Z) begin
         mapped = MAP_BITS'(char_code - CHAR_A) + MAP_FIRST;
      end else if (char_code == CHAR_SPACE) begin
         mapped = MAP_SPACE;
      end else begin
         mapped = '0;
      end
   end

   always_comb begin
      rem = '0;
      for (int i = MAP_BITS - 1; i >= 0; i--) begin
         rem = {rem[MAP_BITS-1:0], mapped[i]};
         if (MOD_BITS'(rem) >= modulus) begin
            rem = (MAP_BITS+1)'(MOD_BITS'(rem) - modulus);
         end
      end
      base_in = MOD_BITS'(rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
      base_ff <= base_in;
   end

   assign ctrl_out = ctrl_ff;
   assign base_out = base_ff;

endmodule

// ===== rtl/lrme_step.sv =====
// One shift-and-add step of the square and the multiply of one exponent bit.
module lrme_step #(
   parameter int MOD_BITS = lrme_pkg::MOD_BITS_DEFAULT,
   parameter int BIT_IDX  = 0,
   parameter bit FIRST    = 1'b0,
   parameter bit LAST     = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lrme_pkg::stage_ctrl_type ctrl_in,
   input  logic [MOD_BITS-1:0]      base_in_d,
   input  logic [MOD_BITS-1:0]      result_in_d,
   input  logic [MOD_BITS-1:0]      acc_sq_in_d,
   input  logic [MOD_BITS-1:0]      acc_mul_in_d,
   input  logic [MOD_BITS-1:0]      modulus,
   input  logic                     exp_bit,
   output lrme_pkg::stage_ctrl_type ctrl_out,
   output logic [MOD_BITS-1:0]      base_out,
   output logic [MOD_BITS-1:0]      result_out,
   output logic [MOD_BITS-1:0]      acc_sq_out,
   output logic [MOD_BITS-1:0]      acc_mul_out
);
   import lrme_pkg::*;

   function automatic logic [MOD_BITS-1:0] add_mod(input logic [MOD_BITS-1:0] a,
                                                   input logic [MOD_BITS-1:0] b,
                                                   input logic [MOD_BITS-1:0] m);
      logic [MOD_BITS-1:0] gap;
      gap = m - b;
      if (a >= gap) begin
         return a - gap;
      end
      return a + b;
   endfunction

   stage_ctrl_type      ctrl_ff;
   logic [MOD_BITS-1:0] base_ff, result_ff, acc_sq_ff, acc_mul_ff;
   logic [MOD_BITS-1:0] base_in, result_in, acc_sq_in, acc_mul_in;
   logic [MOD_BITS-1:0] sq0, mul0;

   always_comb begin
      sq0  = FIRST ? '0 : acc_sq_in_d;
      mul0 = FIRST ? '0 : acc_mul_in_d;
      acc_sq_in  = add_mod(sq0, sq0, modulus);
      acc_mul_in = add_mod(mul0, mul0, modulus);
      if (base_in_d[BIT_IDX]) begin
         acc_sq_in  = add_mod(acc_sq_in, base_in_d, modulus);
         acc_mul_in = add_mod(acc_mul_in, result_in_d, modulus);
      end
      base_in   = base_in_d;
      result_in = result_in_d;
      if (LAST) begin
         base_in = acc_sq_in;
         if (exp_bit) begin
            result_in = acc_mul_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
      base_ff    <= base_in;
      result_ff  <= result_in;
      acc_sq_ff  <= acc_sq_in;
      acc_mul_ff <= acc_mul_in;
   end

   assign ctrl_out    = ctrl_ff;
   assign base_out    = base_ff;
   assign result_out  = result_ff;
   assign acc_sq_out  = acc_sq_ff;
   assign acc_mul_out = acc_mul_ff;

endmodule
